FILE: rtl/core/kmd_pkg.sv
// Shared types and constants of the key matrix debouncer.
package kmd_pkg;

    localparam int ROW_COUNT_DEF    = 8;
    localparam int COLUMN_COUNT_DEF = 8;
    localparam int SAMPLE_WIDTH     = 8;
    localparam int ROW_W            = 3;
    localparam int COL_W            = 3;
    localparam int CTR_W            = 3;

    localparam logic [CTR_W-1:0] THRESH_RESET = 3'd4;

    typedef struct packed {
        logic [ROW_W-1:0]        scan_row;
        logic [SAMPLE_WIDTH-1:0] key_bits;
    } t_in_word;

    typedef struct packed {
        logic [ROW_W-1:0] event_row;
        logic [COL_W-1:0] event_column;
        logic             is_press;
        logic             last_event;
    } t_out_word;

endpackage

FILE: rtl/core/key_matrix_debouncer_top.sv
// Key matrix debouncer: per-key stability counters, one row scan per word.
// Path: input word register, then pending event mask, then output word register.
// Throughput: one scan per cycle when it raises at most one event and the output
// is not stalled; further events drain one by one via the single output register.
// Reset (synchronous, active low) clears all key state and sets the threshold to 4.
module key_matrix_debouncer_top #(
    parameter int ROW_COUNT    = kmd_pkg::ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = kmd_pkg::COLUMN_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  kmd_pkg::t_in_word            i_in_word,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output kmd_pkg::t_out_word           o_out_word,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [kmd_pkg::CTR_W-1:0]    i_cfg_data
);

    localparam int SROWS  = (ROW_COUNT < kmd_pkg::SAMPLE_WIDTH) ? ROW_COUNT
                                                               : kmd_pkg::SAMPLE_WIDTH;
    localparam int SCOLS  = (COLUMN_COUNT < kmd_pkg::SAMPLE_WIDTH) ? COLUMN_COUNT
                                                                  : kmd_pkg::SAMPLE_WIDTH;
    localparam int RIDX_W = (SROWS > 1) ? $clog2(SROWS) : 1;

    logic [kmd_pkg::CTR_W-1:0]                 r_thresh;
    logic                                      r_in_v;
    kmd_pkg::t_in_word                         r_in_word;
    logic [SCOLS-1:0]                          r_prev [SROWS];
    logic [SCOLS-1:0]                          r_acc  [SROWS];
    logic [SCOLS-1:0][kmd_pkg::CTR_W-1:0]      r_ctr  [SROWS];
    logic [SCOLS-1:0]                          r_pend_mask;
    logic [SCOLS-1:0]                          r_pend_press;
    logic [kmd_pkg::ROW_W-1:0]                 r_pend_row;
    logic                                      r_out_v;
    kmd_pkg::t_out_word                        r_out_word;

    logic [SCOLS-1:0]                          n_pend_mask;
    logic [SCOLS-1:0]                          n_prev_row;
    logic [SCOLS-1:0]                          n_acc_row;
    logic [SCOLS-1:0][kmd_pkg::CTR_W-1:0]      n_ctr_row;

    logic [RIDX_W-1:0]                         row_idx;
    logic                                      row_ok;
    logic [SCOLS-1:0]                          sample;
    logic [SCOLS-1:0]                          rd_prev;
    logic [SCOLS-1:0]                          rd_acc;
    logic [SCOLS-1:0][kmd_pkg::CTR_W-1:0]      rd_ctr;
    logic [SCOLS-1:0]                          ev_raw;
    logic [SCOLS-1:0]                          ev_mask;
    logic [SCOLS-1:0]                          low;
    logic [SCOLS-1:0]                          rest;
    logic [SCOLS-1:0]                          pend_after;
    logic [kmd_pkg::COL_W-1:0]                 low_col;
    logic                                      out_load;
    logic                                      take;
    logic                                      fire;
    logic                                      in_accept;

    assign row_idx = r_in_word.scan_row[RIDX_W-1:0];
    assign row_ok  = {1'b0, r_in_word.scan_row} < (kmd_pkg::ROW_W+1)'(SROWS);
    assign sample  = r_in_word.key_bits[SCOLS-1:0];
    assign rd_prev = r_prev[row_idx];
    assign rd_acc  = r_acc[row_idx];
    assign rd_ctr  = r_ctr[row_idx];

    // per-key debounce step
    always_comb begin
        n_prev_row = sample;
        n_acc_row  = rd_acc;
        n_ctr_row  = rd_ctr;
        ev_raw     = '0;
        for (int c = 0; c < SCOLS; c++) begin
            if ((sample[c] ^ rd_prev[c]) && (sample[c] ^ rd_acc[c])) begin
                n_ctr_row[c] = '0;
            end else if (sample[c] ^ rd_acc[c]) begin
                if (rd_ctr[c] < r_thresh) begin
                    n_ctr_row[c] = rd_ctr[c] + 1'b1;
                    if (n_ctr_row[c] == r_thresh) begin
                        n_acc_row[c] = sample[c];
                        ev_raw[c]    = 1'b1;
                    end
                end
            end
        end
    end

    assign ev_mask = row_ok ? ev_raw : '0;

    // drain pending events lowest column first
    assign out_load   = !r_out_v || !i_out_stall;
    assign take       = (r_pend_mask != '0) && out_load;
    assign low        = r_pend_mask & (~r_pend_mask + 1'b1);
    assign rest       = r_pend_mask & ~low;
    assign pend_after = take ? rest : r_pend_mask;
    assign fire       = r_in_v && (pend_after == '0);
    assign n_pend_mask = fire ? ev_mask : pend_after;

    always_comb begin
        low_col = '0;
        for (int c = 0; c < SCOLS; c++) begin
            if (low[c]) begin
                low_col = low_col | kmd_pkg::COL_W'(c);
            end
        end
    end

    assign o_in_stall  = r_in_v && !fire;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= kmd_pkg::THRESH_RESET;
            r_in_v      <= 1'b0;
            r_pend_mask <= '0;
            r_out_v     <= 1'b0;
            for (int r = 0; r < SROWS; r++) begin
                r_prev[r] <= '0;
                r_acc[r]  <= '0;
                r_ctr[r]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_thresh <= i_cfg_data;
            end
            if (in_accept) begin
                r_in_v <= 1'b1;
            end else if (fire) begin
                r_in_v <= 1'b0;
            end
            r_pend_mask <= n_pend_mask;
            if (out_load) begin
                r_out_v <= take;
            end
            if (fire && row_ok) begin
                r_prev[row_idx] <= n_prev_row;
                r_acc[row_idx]  <= n_acc_row;
                r_ctr[row_idx]  <= n_ctr_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_in_word;
        end
        if (fire) begin
            r_pend_row   <= r_in_word.scan_row;
            r_pend_press <= sample;
        end
        if (take) begin
            r_out_word.event_row    <= r_pend_row;
            r_out_word.event_column <= low_col;
            r_out_word.is_press     <= |(low & r_pend_press);
            r_out_word.last_event   <= (rest == '0);
        end
    end

endmodule

FILE: rtl/core/kmd_checker.sv
// Port checker for the key matrix debouncer and its bind to the top level.
module kmd_checker #(
    parameter int ROW_COUNT    = kmd_pkg::ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = kmd_pkg::COLUMN_COUNT_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input kmd_pkg::t_out_word o_out_word
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled output word dropped");

    a_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("stalled output word changed");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_out_word.event_row) < ROW_COUNT))
        else $error("event row out of range");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_out_word.event_column) < COLUMN_COUNT))
        else $error("event column out of range");

endmodule

bind key_matrix_debouncer_top kmd_checker #(
    .ROW_COUNT    (ROW_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
) u_kmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
